>>> sv/dnrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual NCO ring modulator package
// Shared types, command bundle, register indexes and sine table constants.
// ----------------------------------------------------------------------------
package dnrm_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int PHASE_BITS_DEF       = 32;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF      = 16;

  // Configuration port geometry and register map.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 31;
  localparam int STEP_W     = 31;
  localparam int AMP_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MOD_STEP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CAR_STEP = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MOD_AMP  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CAR_AMP  = CFG_IDX_W'(3);

  localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(32768);

  // Amplitudes are Q1.15, so the scaled sample is the product shifted by 15.
  localparam int AMP_FRAC = 15;

  // pi in Q2.30, used only while the table is elaborated.
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_MUL_MOD,
    ST_MUL_CAR,
    ST_MUL_RING
  } state_e;

  typedef enum logic [1:0] {
    MUL_MOD,
    MUL_CAR,
    MUL_RING
  } mul_sel_e;

  typedef struct packed {
    logic     load_phase;  // take the phases in (cleared on restart)
    logic     lookup;      // read both table entries and advance the phases
    mul_sel_e mul_sel;     // operands of the shared multiplier
    logic     load_mod;    // store the scaled modulator sample
    logic     load_car;    // store the scaled carrier sample
    logic     load_out;    // fill the output register
  } cmd_t;

endpackage

>>> sv/dnrm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual NCO ring modulator controller
// Sequences the lookup and the three passes through the shared multiplier.
// ----------------------------------------------------------------------------
module dnrm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dnrm_pkg::cmd_t cmd_o
);
  import dnrm_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;

  // The output register can take a new result when it is empty or draining.
  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP:  state_d = ST_MUL_MOD;
      ST_MUL_MOD: state_d = ST_MUL_CAR;
      ST_MUL_CAR: state_d = ST_MUL_RING;
      ST_MUL_RING: begin
        if (out_free) begin
          state_d = in_valid_i ? ST_LOOKUP : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o.load_phase = 1'b0;
    cmd_o.lookup     = 1'b0;
    cmd_o.mul_sel    = MUL_MOD;
    cmd_o.load_mod   = 1'b0;
    cmd_o.load_car   = 1'b0;
    cmd_o.load_out   = 1'b0;
    case (state_q)
      ST_IDLE:    in_ready_o = 1'b1;
      ST_LOOKUP:  cmd_o.lookup = 1'b1;
      ST_MUL_MOD: begin
        cmd_o.mul_sel  = MUL_MOD;
        cmd_o.load_mod = 1'b1;
      end
      ST_MUL_CAR: begin
        cmd_o.mul_sel  = MUL_CAR;
        cmd_o.load_car = 1'b1;
      end
      ST_MUL_RING: begin
        cmd_o.mul_sel  = MUL_RING;
        cmd_o.load_out = out_free;
        in_ready_o     = out_free;
      end
      default: in_ready_o = 1'b0;
    endcase
    cmd_o.load_phase = in_valid_i && in_ready_o;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_to_lookup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_LOOKUP)
    else $error("accepted item did not start a table lookup");

  a_mod_after_lookup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL_MOD |-> $past(state_q) == ST_LOOKUP)
    else $error("modulator multiply not preceded by a lookup");

  a_load_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten before its transfer");

endmodule

>>> sv/dnrm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual NCO ring modulator datapath
// Configuration registers, phase accumulators, sine table and one shared
// multiplier with floor shift and saturation.
// ----------------------------------------------------------------------------
module dnrm_datapath #(
  parameter int PHASE_BITS       = dnrm_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = dnrm_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS      = dnrm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dnrm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dnrm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 restart_i,
  input  dnrm_pkg::cmd_t                       cmd_i,
  output logic signed [SAMPLE_BITS-1:0]        ring_sample_o,
  output logic signed [SAMPLE_BITS-1:0]        mod_sample_o,
  output logic signed [SAMPLE_BITS-1:0]        car_sample_o
);
  import dnrm_pkg::*;

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int PW    = PHASE_BITS + IDX_W;
  localparam int OPW   = (SAMPLE_BITS > AMP_W + 1) ? SAMPLE_BITS : AMP_W + 1;
  localparam int MW    = 2 * OPW;
  localparam longint SampMax = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint Depth   = SINE_TABLE_DEPTH;
  localparam longint OneQ30  = longint'(1) << 30;

  // Configuration registers.
  logic [STEP_W-1:0] mod_step_q, car_step_q;
  logic [AMP_W-1:0]  mod_amp_q, car_amp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_step_q <= '0;
      car_step_q <= '0;
      mod_amp_q  <= AMP_RESET;
      car_amp_q  <= AMP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MOD_STEP: mod_step_q <= cfg_data_i[STEP_W-1:0];
        REG_CAR_STEP: car_step_q <= cfg_data_i[STEP_W-1:0];
        REG_MOD_AMP:  mod_amp_q  <= cfg_data_i[AMP_W-1:0];
        REG_CAR_AMP:  car_amp_q  <= cfg_data_i[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Constant sine table, one entry per phase bin. The angle is folded into
  // [-pi/2, pi/2] and the sine of its magnitude is a Taylor series through
  // x^15 in Q2.30 with truncating steps, clamped to [0, 1.0].
  logic signed [SAMPLE_BITS-1:0] sine_tab [SINE_TABLE_DEPTH];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_tab
    localparam longint U = 4 * longint'(g);
    localparam longint F = (U <= Depth) ? U : ((U <= 3 * Depth) ? 2 * Depth - U
                                                                : U - 4 * Depth);
    localparam longint M   = (F < 0) ? -F : F;
    localparam longint X   = (longint'(PI_Q30 / 2) * M) / SINE_TABLE_DEPTH;
    localparam longint X2  = (X * X) >>> 30;
    localparam longint T1  = ((X  * X2) >>> 30) / 6;
    localparam longint T2  = ((T1 * X2) >>> 30) / 20;
    localparam longint T3  = ((T2 * X2) >>> 30) / 42;
    localparam longint T4  = ((T3 * X2) >>> 30) / 72;
    localparam longint T5  = ((T4 * X2) >>> 30) / 110;
    localparam longint T6  = ((T5 * X2) >>> 30) / 156;
    localparam longint T7  = ((T6 * X2) >>> 30) / 210;
    localparam longint SUM = X - T1 + T2 - T3 + T4 - T5 + T6 - T7;
    localparam longint S   = (SUM < 0) ? 0 : ((SUM > OneQ30) ? OneQ30 : SUM);
    localparam longint V   = (SampMax * S + (longint'(1) << 29)) >>> 30;
    localparam longint E   = (F < 0) ? -V : V;
    assign sine_tab[g] = SAMPLE_BITS'(E);
  end

  // Phase accumulators.
  logic [PHASE_BITS-1:0] mod_phase_q, car_phase_q;
  logic [PHASE_BITS-1:0] mod_phase_d, car_phase_d;

  always_comb begin
    mod_phase_d = mod_phase_q;
    car_phase_d = car_phase_q;
    if (cmd_i.load_phase && restart_i) begin
      mod_phase_d = '0;
      car_phase_d = '0;
    end else if (cmd_i.lookup) begin
      mod_phase_d = mod_phase_q + PHASE_BITS'(mod_step_q);
      car_phase_d = car_phase_q + PHASE_BITS'(car_step_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_phase_q <= '0;
      car_phase_q <= '0;
    end else begin
      mod_phase_q <= mod_phase_d;
      car_phase_q <= car_phase_d;
    end
  end

  // Table index is the phase scaled by the depth, top bits kept.
  logic [PW-1:0]    mod_scaled, car_scaled;
  logic [IDX_W-1:0] mod_idx, car_idx;

  assign mod_scaled = PW'(mod_phase_q) * PW'(SINE_TABLE_DEPTH);
  assign car_scaled = PW'(car_phase_q) * PW'(SINE_TABLE_DEPTH);
  assign mod_idx    = mod_scaled[PW-1 -: IDX_W];
  assign car_idx    = car_scaled[PW-1 -: IDX_W];

  logic signed [SAMPLE_BITS-1:0] mod_tab_q, car_tab_q;
  logic signed [SAMPLE_BITS-1:0] mod_s_q, car_s_q;
  logic signed [SAMPLE_BITS-1:0] ring_o_q, mod_o_q, car_o_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      mod_tab_q <= sine_tab[mod_idx];
      car_tab_q <= sine_tab[car_idx];
    end
  end

  // Shared multiplier, followed by a floor shift and saturation.
  logic signed [OPW-1:0] mul_a, mul_b;
  logic signed [MW-1:0]  prod, shifted, sat_val;
  logic signed [SAMPLE_BITS-1:0] mul_res;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_MOD: begin
        mul_a = OPW'(mod_tab_q);
        mul_b = OPW'({1'b0, mod_amp_q});
      end
      MUL_CAR: begin
        mul_a = OPW'(car_tab_q);
        mul_b = OPW'({1'b0, car_amp_q});
      end
      MUL_RING: begin
        mul_a = OPW'(mod_s_q);
        mul_b = OPW'(car_s_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign shifted = (cmd_i.mul_sel == MUL_RING) ? (prod >>> (SAMPLE_BITS - 1))
                                               : (prod >>> AMP_FRAC);

  always_comb begin
    if (shifted > MW'(SampMax)) begin
      sat_val = MW'(SampMax);
    end else if (shifted < MW'(-SampMax - 1)) begin
      sat_val = MW'(-SampMax - 1);
    end else begin
      sat_val = shifted;
    end
  end

  assign mul_res = SAMPLE_BITS'(sat_val);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_mod) begin
      mod_s_q <= mul_res;
    end
    if (cmd_i.load_car) begin
      car_s_q <= mul_res;
    end
    if (cmd_i.load_out) begin
      ring_o_q <= mul_res;
      mod_o_q  <= mod_s_q;
      car_o_q  <= car_s_q;
    end
  end

  assign ring_sample_o = ring_o_q;
  assign mod_sample_o  = mod_o_q;
  assign car_sample_o  = car_o_q;

endmodule

>>> sv/dual_nco_ring_modulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual NCO ring modulator
// Two sine oscillators (modulator and carrier) and their ring product.
// ----------------------------------------------------------------------------
// Each input transfer is one sample tick. When restart is set both phase
// accumulators are zeroed first; then each phase picks an entry of a constant
// sine table, the entry is scaled by its Q1.15 amplitude, and the two scaled
// samples are multiplied into the ring sample (floor shift by SAMPLE_BITS-1,
// saturated). After the table entries are read each phase advances by its step and
// wraps at a full turn. One output transfer follows each input transfer, in
// order. A tick runs through the table lookup and then three passes through the
// single shared multiplier (modulator, carrier, ring product); input is held
// off during the lookup and the first two passes.
// A finished result waits in the output register, so the next tick is accepted
// while it is still pending; beyond those steps the block only holds off input
// when that register is still full at the end of the ring product pass.
// Configuration registers are written through a plain write port and take
// effect on the next tick; write them while no tick is in flight.
// ----------------------------------------------------------------------------
module dual_nco_ring_modulator #(
  parameter int PHASE_BITS       = dnrm_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = dnrm_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS      = dnrm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [dnrm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dnrm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Tick input channel.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              restart_i,
  // Sample output channel.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]     ring_sample_o,
  output logic signed [SAMPLE_BITS-1:0]     mod_sample_o,
  output logic signed [SAMPLE_BITS-1:0]     car_sample_o
);
  import dnrm_pkg::*;

  cmd_t cmd;

  // The controller owns both handshakes and the output valid flag.
  dnrm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // The datapath holds configuration, phases, the table and the multiplier.
  dnrm_datapath #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .restart_i     (restart_i),
    .cmd_i         (cmd),
    .ring_sample_o (ring_sample_o),
    .mod_sample_o  (mod_sample_o),
    .car_sample_o  (car_sample_o)
  );

endmodule
